>>> rtl/sacia_pkg.sv
`timescale 1ns / 1ps

package sacia_pkg;

    // Status and control bit patterns
    localparam logic [7:0] STATUS_TX_EMPTY = 8'h10;
    localparam logic [7:0] STATUS_IRQ      = 8'h80;
    localparam logic [7:0] CONTROL_FORCED  = 8'h10;

    // Offset decode
    localparam int unsigned CTRL_SEL_BIT = 3;
    localparam logic [3:0]  SW_OFFSET_ONE = 4'd1;
    localparam logic [3:0]  SW_OFFSET_TWO = 4'd2;

    // Command register transmit-interrupt mode (bits 3:2)
    localparam logic [1:0] TX_IRQ_MODE = 2'b01;

    // Configuration register indexes
    localparam logic [1:0] CFG_SWITCH_ONE = 2'd0;
    localparam logic [1:0] CFG_SWITCH_TWO = 2'd1;
    localparam logic [1:0] CFG_SINK_EN    = 2'd2;

    typedef enum logic [1:0] {
        REG_DATA    = 2'd0,
        REG_STATUS  = 2'd1,
        REG_COMMAND = 2'd2,
        REG_CONTROL = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic [7:0] switch_one;
        logic [7:0] switch_two;
        logic       sink_en;
    } cfg_t;

    typedef struct packed {
        logic       is_write;
        logic [3:0] offset;
        logic [7:0] wdata;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       irq_pending;
    } result_t;

    function automatic logic tx_irq_on(input logic [7:0] cmd);
        tx_irq_on = cmd[0] && (cmd[3:2] == TX_IRQ_MODE);
    endfunction

endpackage

>>> rtl/sacia_cfg.sv
`timescale 1ns / 1ps

module sacia_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output sacia_pkg::cfg_t     cfg
);
    import sacia_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SWITCH_ONE: cfg_next.switch_one = cfg_data;
                CFG_SWITCH_TWO: cfg_next.switch_two = cfg_data;
                CFG_SINK_EN:    cfg_next.sink_en    = cfg_data[0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sacia_core.sv
`timescale 1ns / 1ps

module sacia_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sacia_pkg::access_t  access,
    input  sacia_pkg::cfg_t     cfg,
    output sacia_pkg::result_t  result
);
    import sacia_pkg::*;

    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    logic [7:0] ctrl_reg;
    logic [7:0] ctrl_next;
    logic       irq_latch_reg;
    logic       irq_latch_next;
    reg_sel_t   sel;
    logic       ctrl_area;

    assign sel       = reg_sel_t'(access.offset[1:0]);
    assign ctrl_area = access.offset[CTRL_SEL_BIT];

    always_comb
    begin
        cmd_next          = cmd_reg;
        ctrl_next         = ctrl_reg;
        irq_latch_next    = irq_latch_reg;
        result.read_data  = '0;
        result.tx_valid   = 1'b0;
        result.tx_data    = '0;

        if (!ctrl_area)
        begin
            // switch area: reads only
            if (!access.is_write)
            begin
                if (access.offset == SW_OFFSET_ONE)
                begin
                    result.read_data = cfg.switch_one;
                end
                else if (access.offset == SW_OFFSET_TWO)
                begin
                    result.read_data = cfg.switch_two;
                end
            end
        end
        else if (!access.is_write)
        begin
            unique case (sel)
                REG_DATA:    result.read_data = '0;
                REG_STATUS:
                begin
                    result.read_data = STATUS_TX_EMPTY | (irq_latch_reg ? STATUS_IRQ : 8'h00);
                    irq_latch_next   = 1'b0;
                end
                REG_COMMAND: result.read_data = cmd_reg;
                REG_CONTROL: result.read_data = ctrl_reg;
                default:     result.read_data = '0;
            endcase
        end
        else
        begin
            unique case (sel)
                REG_DATA:
                begin
                    result.tx_valid = cfg.sink_en;
                    result.tx_data  = cfg.sink_en ? access.wdata : 8'h00;
                    if (tx_irq_on(cmd_reg))
                    begin
                        irq_latch_next = 1'b1;
                    end
                end
                REG_STATUS:
                begin
                    // programmed reset
                    cmd_next       = '0;
                    ctrl_next      = '0;
                    irq_latch_next = 1'b0;
                end
                REG_COMMAND:
                begin
                    cmd_next = access.wdata;
                    if (tx_irq_on(access.wdata) && !tx_irq_on(cmd_reg))
                    begin
                        irq_latch_next = 1'b1;
                    end
                end
                REG_CONTROL: ctrl_next = access.wdata | CONTROL_FORCED;
                default:     ctrl_next = ctrl_reg;
            endcase
        end

        result.irq_pending = irq_latch_next && cmd_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            ctrl_reg      <= '0;
            irq_latch_reg <= 1'b0;
        end
        else if (fire)
        begin
            cmd_reg       <= cmd_next;
            ctrl_reg      <= ctrl_next;
            irq_latch_reg <= irq_latch_next;
        end
    end

    // status read always leaves the latch clear
    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctrl_area && !access.is_write && sel == REG_STATUS |=> !irq_latch_reg)
        else $error("irq latch survived a status read");

    // control register is zero or carries the forced bit
    a_ctrl_forced: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg != 8'h00 |-> ctrl_reg[4])
        else $error("control register lost forced bit");

    // switch-area writes leave state untouched
    a_switch_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !ctrl_area && access.is_write |=>
            $stable(cmd_reg) && $stable(ctrl_reg) && $stable(irq_latch_reg))
        else $error("switch-area write changed state");

endmodule

>>> rtl/serial_acia_bus_registers_core.sv
`timescale 1ns / 1ps

// Bus register block of a serial controller. Each request is one bus access
// (command 0 read / 1 write, 4-bit offset, write byte) and yields exactly one
// response carrying the read byte, the transmit byte handed to the sink and
// the interrupt line. Throughput is one request per cycle while the output
// is not stalled: a request is captured in the input register, decoded and
// applied to the command, control and interrupt-latch state in a single
// pass, and lands in the response register once the output stage is free.
// The input register keeps accepting while a response waits behind a
// stalled output; in_stall rises only when both stages are full.
// The switch bytes and sink enable are written through the cfg port, which
// is always ready; write them only while no request is in flight.
module serial_acia_bus_registers_core (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [3:0] offset,
    input  logic [7:0] write_data,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic [7:0] tx_data,
    output logic       irq_pending,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import sacia_pkg::*;

    cfg_t    cfg;
    access_t acc_reg;
    logic    acc_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;
    logic    in_take;

    // Output stage frees up when empty or when its response is taken.
    assign advance  = !out_valid_reg || !out_stall;
    // Move the captured request into the response register.
    assign fire     = acc_valid_reg && advance;
    // Hold off new requests only when the input register cannot drain.
    assign in_stall = acc_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    sacia_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sacia_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .access (acc_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    // Input register: control bit under reset, payload loads on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
        end
        else if (advance || !acc_valid_reg)
        begin
            acc_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            acc_reg.is_write <= command;
            acc_reg.offset   <= offset;
            acc_reg.wdata    <= write_data;
        end
    end

    // Response register: drop valid once taken, refill on fire.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = res_reg.read_data;
    assign tx_valid    = res_reg.tx_valid;
    assign tx_data     = res_reg.tx_data;
    assign irq_pending = res_reg.irq_pending;

    // A response without a transmit carries a zero transmit byte.
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.tx_valid |-> res_reg.tx_data == 8'h00)
        else $error("tx_data nonzero without tx_valid");

    // A transmit comes only from a write, which reads back zero.
    a_tx_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.tx_valid |-> res_reg.read_data == 8'h00)
        else $error("transmit response with read data");

    // Stall only while a request is held in the input register.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> acc_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline");

endmodule

>>> tb/serial_acia_bus_registers_core_tb.sv
`timescale 1ns / 1ps

module serial_acia_bus_registers_core_tb;

    import sacia_pkg::*;

    // Access kinds on the command input
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // Controller offsets (bit3 set, low bits pick the register)
    localparam logic [3:0] OFF_DATA    = {2'b10, REG_DATA};
    localparam logic [3:0] OFF_STATUS  = {2'b10, REG_STATUS};
    localparam logic [3:0] OFF_COMMAND = {2'b10, REG_COMMAND};
    localparam logic [3:0] OFF_CONTROL = {2'b10, REG_CONTROL};

    // Worst case per request is the longest sender gap plus the longest
    // receiver stall; ~1000 requests stay far below this limit.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 155;
    localparam int unsigned RANDOM_PHASES = 6;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       command = 1'b0;
    logic [3:0] offset = 4'h0;
    logic [7:0] write_data = 8'h00;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       irq_pending;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'h00;

    serial_acia_bus_registers_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .offset      (offset),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .tx_valid    (tx_valid),
        .tx_data     (tx_data),
        .irq_pending (irq_pending),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    // Mirror of the block: configuration and register state
    logic [7:0] sw_one_cfg;
    logic [7:0] sw_two_cfg;
    logic       sink_en_cfg;
    logic [7:0] mirror_cmd;
    logic [7:0] mirror_ctrl;
    logic       mirror_irq;

    // Responses still owed by the block, oldest first
    result_t expected_replies[$];

    typedef struct {
        access_t acc;
        logic    known;
        result_t want;
    } dir_row_t;

    dir_row_t directed_rows[$];

    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned n_requests = 0;
    int unsigned n_responses = 0;
    int unsigned n_tx_bytes = 0;
    int unsigned n_irq_seen = 0;
    int unsigned stall_left = 0;
    bit          no_idle = 1'b0;

    // Transmit interrupt armed: bit0 set and mode bits 3:2 in transmit mode
    function automatic logic xmit_irq_armed(input logic [7:0] cmd);
        return cmd[0] && (cmd[3:2] == TX_IRQ_MODE);
    endfunction

    // Apply one bus access to the mirror and return the response it yields
    function automatic result_t predict_bus_access(input access_t a);
        result_t r;
        logic    was_armed;
        r = '0;
        if (!a.offset[CTRL_SEL_BIT]) begin
            // Switch area: reads of two offsets return the switch bytes, writes drop
            if (!a.is_write) begin
                if (a.offset == SW_OFFSET_ONE)
                    r.read_data = sw_one_cfg;
                else if (a.offset == SW_OFFSET_TWO)
                    r.read_data = sw_two_cfg;
            end
        end else if (!a.is_write) begin
            case (reg_sel_t'(a.offset[1:0]))
                REG_STATUS:
                begin
                    // Transmitter is always empty; reading clears the latch
                    r.read_data = STATUS_TX_EMPTY | (mirror_irq ? STATUS_IRQ : 8'h00);
                    mirror_irq = 1'b0;
                end
                REG_COMMAND: r.read_data = mirror_cmd;
                REG_CONTROL: r.read_data = mirror_ctrl;
                default:     r.read_data = 8'h00;
            endcase
        end else begin
            case (reg_sel_t'(a.offset[1:0]))
                REG_DATA:
                begin
                    if (sink_en_cfg) begin
                        r.tx_valid = 1'b1;
                        r.tx_data  = a.wdata;
                    end
                    if (xmit_irq_armed(mirror_cmd))
                        mirror_irq = 1'b1;
                end
                REG_STATUS:
                begin
                    // Programmed reset: state clears, configuration stays
                    mirror_cmd  = 8'h00;
                    mirror_ctrl = 8'h00;
                    mirror_irq  = 1'b0;
                end
                REG_COMMAND:
                begin
                    // Latch only on the rising edge of the armed condition
                    was_armed  = xmit_irq_armed(mirror_cmd);
                    mirror_cmd = a.wdata;
                    if (xmit_irq_armed(mirror_cmd) && !was_armed)
                        mirror_irq = 1'b1;
                end
                default: mirror_ctrl = a.wdata | CONTROL_FORCED;
            endcase
        end
        r.irq_pending = mirror_irq & mirror_cmd[0];
        return r;
    endfunction

    // Gap length: mostly none, often short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Random request, biased toward arming the interrupt, transmitting and
    // polling status so the latch gets set, seen and cleared often
    function automatic access_t random_access();
        access_t     a;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        a.is_write = 1'($urandom);
        a.offset   = 4'($urandom);
        a.wdata    = 8'($urandom);
        if (roll < 20) begin
            a.is_write = ACC_WRITE;
            a.offset   = {1'b1, 1'($urandom), REG_COMMAND};
            if ($urandom_range(0, 2) != 0)
                a.wdata = {4'($urandom), TX_IRQ_MODE, 1'($urandom), 1'($urandom)};
        end else if (roll < 45) begin
            a.is_write = ACC_WRITE;
            a.offset   = {1'b1, 1'($urandom), REG_DATA};
        end else if (roll < 65) begin
            a.is_write = ACC_READ;
            a.offset   = {1'b1, 1'($urandom), REG_STATUS};
        end else if (roll < 77) begin
            a.is_write = ACC_READ;
            a.offset[CTRL_SEL_BIT] = 1'b1;
        end else if (roll < 81) begin
            a.is_write = ACC_WRITE;
            a.offset   = {1'b1, 1'($urandom), REG_STATUS};
        end
        return a;
    endfunction

    // Send one request: idle for a random gap, present it, hold it until taken
    task automatic push_access(input access_t a, input logic known, input result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= a.is_write;
        offset     <= a.offset;
        write_data <= a.wdata;
        do
            @(posedge clk);
        while (in_stall);
        // Run the mirror on every request so its state stays in step
        predicted = predict_bus_access(a);
        expected_replies.push_back(known ? want : predicted);
        n_requests++;
    endtask

    // Drop valid and hold until every owed response has come back
    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all three configuration registers back to back, then drop valid
    task automatic set_config(input logic [7:0] sw1, input logic [7:0] sw2, input logic sink);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SWITCH_ONE;
        cfg_data  <= sw1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SWITCH_TWO;
        cfg_data  <= sw2;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SINK_EN;
        cfg_data  <= {7'd0, sink};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sw_one_cfg  = sw1;
        sw_two_cfg  = sw2;
        sink_en_cfg = sink;
    endtask

    task automatic add_row(input logic wr, input logic [3:0] off, input logic [7:0] wd,
                           input logic known, input logic [7:0] rd, input logic tv,
                           input logic [7:0] td, input logic irq);
        dir_row_t row;
        row.acc  = '{is_write: wr, offset: off, wdata: wd};
        row.known = known;
        row.want = '{read_data: rd, tx_valid: tv, tx_data: td, irq_pending: irq};
        directed_rows.push_back(row);
    endtask

    // Receiver side: random stall runs, each followed by out_stall going low
    always @(posedge clk) begin
        if (!rst_n || no_idle) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left == 0) begin
            out_stall  <= 1'b0;
            stall_left = pick_gap();
        end else begin
            out_stall <= 1'b1;
            stall_left--;
        end
    end

    // Compare each taken response with the oldest one owed
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            n_responses++;
            if (tx_valid)
                n_tx_bytes++;
            if (irq_pending)
                n_irq_seen++;
            if (expected_replies.size() == 0) begin
                $error("response with none owed: read_data %0h tx_valid %0b", read_data,
                       tx_valid);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           want.read_data, read_data);
                    errors++;
                end
                if (tx_valid !== want.tx_valid) begin
                    $error("tx_valid mismatch: expected %0b, actual %0b",
                           want.tx_valid, tx_valid);
                    errors++;
                end
                if (tx_data !== want.tx_data) begin
                    $error("tx_data mismatch: expected %0h, actual %0h",
                           want.tx_data, tx_data);
                    errors++;
                end
                if (irq_pending !== want.irq_pending) begin
                    $error("irq_pending mismatch: expected %0b, actual %0b",
                           want.irq_pending, irq_pending);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned ph;
        int unsigned i;

        mirror_cmd  = 8'h00;
        mirror_ctrl = 8'h00;
        mirror_irq  = 1'b0;
        sw_one_cfg  = 8'h00;
        sw_two_cfg  = 8'h00;
        sink_en_cfg = 1'b0;

        // Directed table. Known responses are typed in; the rest come from
        // the mirror. Switch bytes at the extremes, sink on.
        //      wr         offset       wdata  known rd     tv    td     irq
        add_row(ACC_READ,  OFF_STATUS,  8'h00, 1'b1, 8'h10, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  OFF_COMMAND, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  OFF_CONTROL, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  OFF_DATA,    8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  SW_OFFSET_ONE, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  SW_OFFSET_TWO, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  4'h0,        8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  4'h7,        8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        // Switch area write is dropped
        add_row(ACC_WRITE, 4'h3,        8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        // Control write forces bit4
        add_row(ACC_WRITE, OFF_CONTROL, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  OFF_CONTROL, 8'h00, 1'b1, 8'h10, 1'b0, 8'h00, 1'b0);
        add_row(ACC_WRITE, OFF_CONTROL, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  4'hF,        8'h00, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
        // Transmit with the sink on, data extremes
        add_row(ACC_WRITE, OFF_DATA,    8'h00, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0);
        add_row(ACC_WRITE, 4'hC,        8'hFF, 1'b1, 8'h00, 1'b1, 8'hFF, 1'b0);
        // Arm the transmit interrupt: latch sets on the enable edge
        add_row(ACC_WRITE, OFF_COMMAND, 8'h05, 1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
        add_row(ACC_READ,  OFF_COMMAND, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        // Status read reports then clears the latch
        add_row(ACC_READ,  OFF_STATUS,  8'h00, 1'b1, 8'h90, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  4'hD,        8'h00, 1'b1, 8'h10, 1'b0, 8'h00, 1'b0);
        // Rewriting an already armed command does not latch
        add_row(ACC_WRITE, OFF_COMMAND, 8'h05, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        // Data write while armed latches
        add_row(ACC_WRITE, OFF_DATA,    8'h5A, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        // Bit0 off masks the line, bit0 back on shows the held latch
        add_row(ACC_WRITE, OFF_COMMAND, 8'h04, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_WRITE, 4'hE,        8'hF1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        // Programmed reset through a status write
        add_row(ACC_WRITE, OFF_STATUS,  8'hA5, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
        add_row(ACC_READ,  OFF_COMMAND, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);

        // Hold reset, then release it once for the whole run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'hFF, 8'h00, 1'b1);
        for (i = 0; i < directed_rows.size(); i++)
            push_access(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].want);
        drain_requests();

        // Random phases; reconfigure only once the block has gone quiet.
        // The first phase runs with no idling on either side.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       set_config(8'h00, 8'hFF, 1'b0);
                1:       set_config(8'h00, 8'h00, 1'b1);
                2:       set_config(8'hFF, 8'hFF, 1'b0);
                3:       set_config(8'($urandom), 8'($urandom), 1'b1);
                default: set_config(8'($urandom), 8'($urandom), 1'($urandom));
            endcase
            no_idle = (ph == 0);
            repeat (RANDOM_PER_PHASE)
                push_access(random_access(), 1'b0, '0);
            drain_requests();
        end

        $display("Run covered %0d requests over %0d config settings, %0d responses checked.",
                 n_requests, RANDOM_PHASES + 1, n_responses);
        $display("%0d bytes reached the sink; %0d responses carried a raised interrupt.",
                 n_tx_bytes, n_irq_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/sacia_pkg.sv
rtl/sacia_cfg.sv
rtl/sacia_core.sv
rtl/serial_acia_bus_registers_core.sv
tb/serial_acia_bus_registers_core_tb.sv
